// ----- hdl/tor_pkg.sv -----
`default_nettype none

package tor_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;

  localparam int unsigned TTYPE_LEN = 10;
  localparam int unsigned REPLY_LEN = 3;
  localparam int unsigned IDX_W     = $clog2(TTYPE_LEN);

  typedef enum logic [3:0] {
    PH_DATA = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_OPT  = 4'b0100,
    PH_SUB  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_TTYPE = 2'd2
  } act_kind_t;

  typedef struct packed {
    act_kind_t  kind;
    logic [7:0] cmd;
    logic [7:0] value;
  } action_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Terminal-type reply: IAC SB TTYPE IS "ANSI" IAC SE
  function automatic logic [7:0] ttype_byte(input idx_t i);
    logic [7:0] b;
    case (i)
      idx_t'(0): b = B_IAC;
      idx_t'(1): b = B_SB;
      idx_t'(2): b = OPT_TTYPE;
      idx_t'(3): b = 8'd0;
      idx_t'(4): b = 8'd65;
      idx_t'(5): b = 8'd78;
      idx_t'(6): b = 8'd83;
      idx_t'(7): b = 8'd73;
      idx_t'(8): b = B_IAC;
      idx_t'(9): b = B_SE;
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic idx_t last_idx(input act_kind_t k);
    idx_t r;
    case (k)
      ACT_PASS:  r = idx_t'(0);
      ACT_REPLY: r = idx_t'(REPLY_LEN - 1);
      ACT_TTYPE: r = idx_t'(TTYPE_LEN - 1);
      default:   r = idx_t'(0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tor_if.sv -----
`default_nettype none

interface tor_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tor_out_if;
  logic       valid;
  logic       ready;
  logic       to_server;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output to_server, output out_byte, output last, input ready);
  modport sink   (input valid, input to_server, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/telnet_option_responder.sv -----
// An accepted item is registered in the queue, then in the emitter, before
// its first result leaves. One input item per cycle while the queue has room;
// results drain at one per cycle while the receiver is ready. A run of three
// (option reply) or ten (terminal-type reply) results holds the output, and the two-entry queue then fills.
// Reset (rst, synchronous, active high): data phase, held command zero,
// queue and output empty.
`default_nettype none

module telnet_option_responder
  import tor_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  tor_in_if.sink    rx,
  tor_out_if.source tx
);

  // Front: track the command phase and turn each item into at most one action.
  action_t f_act;
  logic    f_valid, f_ready;

  // Back: expand the queued action into its result run.
  action_t b_act;
  logic    b_valid, b_ready;

  tor_classifier u_classifier (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .act       (f_act),
    .act_valid (f_valid),
    .act_ready (f_ready)
  );

  // Decouple: hold up to two actions so input keeps flowing during a run.
  tor_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_act   (f_act),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_act    (b_act),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  tor_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .act       (b_act),
    .act_valid (b_valid),
    .act_ready (b_ready),
    .tx        (tx)
  );

endmodule

`default_nettype wire

// ----- hdl/tor_classifier.sv -----
`default_nettype none

module tor_classifier
  import tor_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  tor_in_if.sink       rx,
  output action_t      act,
  output logic         act_valid,
  input  wire logic    act_ready
);

  phase_t     phase, phase_next;
  logic [7:0] held_command, held_command_next;
  logic       has_act;
  logic       accepted;
  logic [7:0] b;

  assign b         = rx.rx_byte;
  assign rx.ready  = act_ready;
  assign accepted  = rx.valid && rx.ready;
  assign act_valid = accepted && has_act;

  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    has_act           = 1'b0;
    act.kind          = ACT_PASS;
    act.cmd           = 8'd0;
    act.value         = b;
    case (phase)
      PH_DATA: begin
        if (b == B_IAC) begin
          phase_next = PH_CMD;
        end else begin
          has_act = 1'b1;
        end
      end
      PH_CMD: begin
        held_command_next = b;
        phase_next        = PH_OPT;
      end
      PH_OPT: begin
        phase_next = PH_DATA;
        if (held_command == B_DO && (b inside {OPT_SGA, OPT_TTYPE})) begin
          has_act  = 1'b1;
          act.kind = ACT_REPLY;
          act.cmd  = B_WILL;
        end else if (held_command inside {B_WILL, B_WONT}) begin
          has_act  = 1'b1;
          act.kind = ACT_REPLY;
          act.cmd  = (b inside {OPT_ECHO, OPT_SGA, OPT_TTYPE}) ? B_DO : B_DONT;
        end else if (held_command inside {B_DO, B_DONT}) begin
          has_act  = 1'b1;
          act.kind = ACT_REPLY;
          act.cmd  = B_WONT;
        end else if (held_command == B_SB) begin
          if (b == B_SE) begin
            has_act  = 1'b1;
            act.kind = ACT_TTYPE;
          end else begin
            phase_next = PH_SUB;
          end
        end
      end
      PH_SUB: begin
        // drop everything before SE; SE itself raises the terminal-type reply
        if (b == B_SE) begin
          has_act    = 1'b1;
          act.kind   = ACT_TTYPE;
          phase_next = PH_DATA;
        end
      end
      default: phase_next = PH_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      held_command <= 8'd0;
    end else if (accepted) begin
      phase        <= phase_next;
      held_command <= held_command_next;
    end
  end

  a_iac_starts_cmd: assert property (@(posedge clk) disable iff (rst)
    (accepted && phase == PH_DATA && b == B_IAC) |=> phase == PH_CMD)
    else $error("IAC in data phase did not open a command");

  a_opt_returns: assert property (@(posedge clk) disable iff (rst)
    (accepted && phase == PH_OPT && held_command != B_SB) |=> phase == PH_DATA)
    else $error("option byte did not return to data phase");

endmodule

`default_nettype wire

// ----- hdl/tor_queue.sv -----
`default_nettype none

module tor_queue
  import tor_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire action_t  push_act,
  input  wire logic     push_valid,
  output logic          push_ready,
  output action_t       pop_act,
  output logic          pop_valid,
  input  wire logic     pop_ready
);

  action_t    slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_act    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hdl/tor_emitter.sv -----
`default_nettype none

module tor_emitter
  import tor_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire action_t  act,
  input  wire logic     act_valid,
  output logic          act_ready,
  tor_out_if.source     tx
);

  action_t cur;
  logic    cur_valid;
  idx_t    idx;
  logic    at_last;
  logic    fire;

  assign at_last   = (idx == last_idx(cur.kind));
  assign fire      = tx.valid && tx.ready;
  assign act_ready = !cur_valid || (fire && at_last);

  assign tx.valid     = cur_valid;
  assign tx.to_server = (cur.kind != ACT_PASS);
  assign tx.last      = at_last;

  always_comb begin
    case (cur.kind)
      ACT_PASS:  tx.out_byte = cur.value;
      ACT_REPLY: begin
        if (idx == idx_t'(0))      tx.out_byte = B_IAC;
        else if (idx == idx_t'(1)) tx.out_byte = cur.cmd;
        else                       tx.out_byte = cur.value;
      end
      ACT_TTYPE: tx.out_byte = ttype_byte(idx);
      default:   tx.out_byte = cur.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (act_ready && act_valid) begin
      cur <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= idx_t'(0);
    end else if (act_ready) begin
      cur_valid <= act_valid;
      idx       <= idx_t'(0);
    end else if (fire) begin
      idx <= idx + idx_t'(1);
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= last_idx(cur.kind))
    else $error("emit index past end of run");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (fire && !at_last) |=> cur_valid && idx == $past(idx) + idx_t'(1))
    else $error("emit index did not advance");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  import tor_pkg::*;

  // Random part length, counted in bytes received outside a subnegotiation
  // body (body bytes and the SE that closes the body are not counted).
  localparam int RAND_ITEMS   = 165;
  // Last stretch of the run goes without any idling on either side.
  localparam int QUIET_TAIL   = 40;
  // Long receiver hold-off that backs the block up into its input.
  localparam int LONG_HOLD    = 150;
  localparam int HOLD_AT      = 40;
  // Sender waits here until every pending result has drained.
  localparam int PAUSE_AT     = 120;
  // Settle time given to the block after the last result.
  localparam int DRAIN_CYCLES = 20;

  // One byte leaving the block, with its routing and end-of-run mark.
  typedef struct packed {
    logic       to_server;
    logic [7:0] out_byte;
    logic       last;
  } term_byte_t;

  // How a directed row is checked: by the predictor, or by the bytes typed
  // into the row (nothing, one byte for the user, a three-byte reply).
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_USER,
    CHK_REPLY
  } row_chk_t;

  typedef struct packed {
    logic [7:0] rx;
    row_chk_t   chk;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  // Terminal-type answer: IAC SB TTYPE IS "ANSI" IAC SE.
  localparam logic [7:0] TTYPE_ANSI [10] = '{
    B_IAC, B_SB, OPT_TTYPE, 8'd0, 8'd65, 8'd78, 8'd83, 8'd73, B_IAC, B_SE
  };

  localparam int DIR_LEN = 28;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // lowest data byte goes straight to the user
    '{8'h00,     CHK_USER,  8'h00, 8'h00,     8'h00},
    // DO terminal type: agree with WILL
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_DO,      CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{OPT_TTYPE, CHK_REPLY, B_IAC, B_WILL,    OPT_TTYPE},
    // WILL echo: answer DO
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_WILL,    CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{OPT_ECHO,  CHK_REPLY, B_IAC, B_DO,      OPT_ECHO},
    // WONT for an unknown option: answer DONT
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_WONT,    CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{8'h80,     CHK_REPLY, B_IAC, B_DONT,    8'h80},
    // DONT with the highest option value: answer WONT
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_DONT,    CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{8'hFF,     CHK_REPLY, B_IAC, B_WONT,    8'hFF},
    // DO for an option we refuse: answer WONT
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_DO,      CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{8'h05,     CHK_REPLY, B_IAC, B_WONT,    8'h05},
    // doubled IAC is a command byte, not escaped data; swallow the option
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_DO,      CHK_NONE,  8'h00, 8'h00,     8'h00},
    // SB whose option byte is SE itself closes at once
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_SB,      CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_SE,      CHK_MODEL, 8'h00, 8'h00,     8'h00},
    // subnegotiation with an IAC inside the body, closed by SE
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_SB,      CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{OPT_TTYPE, CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_IAC,     CHK_NONE,  8'h00, 8'h00,     8'h00},
    '{B_SE,      CHK_MODEL, 8'h00, 8'h00,     8'h00},
    // the byte right after SE is plain stream data
    '{B_SE,      CHK_USER,  B_SE,  8'h00,     8'h00}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  tor_in_if  rx_if ();
  tor_out_if tx_if ();

  telnet_option_responder dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, kept in step with every accepted byte.
  phase_t     rx_phase    = PH_DATA;
  logic [7:0] rx_held_cmd = 8'h00;

  // Results still owed by the block, oldest first, and the ones the byte
  // just accepted gives rise to.
  term_byte_t due_bytes [$];
  term_byte_t just_due  [$];

  int          errors      = 0;
  bit          idle_on     = 1'b0;
  int unsigned hold_asked  = 0;

  function automatic void emit(input logic srv, input logic [7:0] b, input logic fin);
    term_byte_t t;
    t.to_server = srv;
    t.out_byte  = b;
    t.last      = fin;
    just_due.push_back(t);
  endfunction

  function automatic void answer(input logic [7:0] cmd, input logic [7:0] opt);
    emit(1'b1, B_IAC, 1'b0);
    emit(1'b1, cmd,   1'b0);
    emit(1'b1, opt,   1'b1);
  endfunction

  function automatic void answer_ttype();
    for (int k = 0; k < 10; k++)
      emit(1'b1, TTYPE_ANSI[k], k == 9);
  endfunction

  // Advance the negotiation state by one received byte; leave the bytes it
  // causes in just_due.
  function automatic void negotiate(input logic [7:0] b);
    logic [7:0] c;
    logic       known;
    c     = rx_held_cmd;
    known = (b == OPT_ECHO) || (b == OPT_SGA) || (b == OPT_TTYPE);
    just_due.delete();
    case (rx_phase)
      PH_DATA: begin
        if (b == B_IAC)
          rx_phase = PH_CMD;
        else
          emit(1'b0, b, 1'b1);
      end
      PH_CMD: begin
        rx_held_cmd = b;
        rx_phase    = PH_OPT;
      end
      PH_OPT: begin
        rx_phase = PH_DATA;
        if (c == B_DO && (b == OPT_SGA || b == OPT_TTYPE))
          answer(B_WILL, b);
        else if ((c == B_WILL || c == B_WONT) && known)
          answer(B_DO, b);
        else if (c == B_WILL || c == B_WONT)
          answer(B_DONT, b);
        else if (c == B_DO || c == B_DONT)
          answer(B_WONT, b);
        else if (c == B_SB) begin
          if (b == B_SE)
            answer_ttype();
          else
            rx_phase = PH_SUB;
        end
      end
      default: begin
        // inside a subnegotiation: drop everything up to SE
        if (b == B_SE) begin
          rx_phase = PH_DATA;
          answer_ttype();
        end
      end
    endcase
  endfunction

  task automatic flag(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Offer one byte, with a random gap ahead of it while idling is on, and
  // hold it until the block takes it. Valid stays high between back-to-back
  // items, so it is never dropped and raised in the same step.
  task automatic send_rx(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_out
    term_byte_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (due_bytes.size() == 0) begin
        flag($sformatf("unexpected byte %0d to_server=%0b last=%0b",
                       tx_if.out_byte, tx_if.to_server, tx_if.last));
      end else begin
        want = due_bytes.pop_front();
        if (tx_if.to_server !== want.to_server)
          flag($sformatf("to_server %0b, want %0b", tx_if.to_server, want.to_server));
        if (tx_if.out_byte !== want.out_byte)
          flag($sformatf("out_byte %0d, want %0d", tx_if.out_byte, want.out_byte));
        if (tx_if.last !== want.last)
          flag($sformatf("last %0b, want %0b", tx_if.last, want.last));
      end
    end
  end

  // Receiver: random stall bursts while idling is on, and one long hold-off
  // on request, counted here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int unsigned holds_seen;
    holds_seen = 0;
    tx_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (holds_seen != hold_asked) begin
        holds_seen = hold_asked;
        tx_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        tx_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk);
      end else begin
        tx_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    logic [7:0] seq [$];
    logic [7:0] x;
    logic [7:0] opt;
    int         fed;
    bit         held;
    bit         paused;

    fed    = 0;
    held   = 1'b0;
    paused = 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: typed rows fix the expected bytes, the others defer
    // to the predictor. The predictor runs on every row to keep its state.
    idle_on = 1'b1;
    for (int i = 0; i < DIR_LEN; i++) begin
      row = DIR_ROWS[i];
      send_rx(row.rx);
      negotiate(row.rx);
      case (row.chk)
        CHK_MODEL: begin
          foreach (just_due[k]) due_bytes.push_back(just_due[k]);
        end
        CHK_USER: begin
          due_bytes.push_back('{1'b0, row.b0, 1'b1});
        end
        CHK_REPLY: begin
          due_bytes.push_back('{1'b1, row.b0, 1'b0});
          due_bytes.push_back('{1'b1, row.b1, 1'b0});
          due_bytes.push_back('{1'b1, row.b2, 1'b1});
        end
        default: ;
      endcase
    end

    // Random part: mostly well-formed telnet sequences with random content,
    // plus stray commands and raw noise.
    while (fed < RAND_ITEMS) begin
      idle_on = (fed < RAND_ITEMS - QUIET_TAIL) && ((fed / 25) % 4 != 3);
      if (!held && fed >= HOLD_AT) begin
        held = 1'b1;
        hold_asked++;
      end
      if (!paused && fed >= PAUSE_AT) begin
        // park the sender until the block has nothing left to say
        paused = 1'b1;
        rx_if.valid <= 1'b0;
        do @(posedge clk); while (due_bytes.size() != 0);
      end

      seq.delete();
      x = 8'($urandom_range(0, 99));
      if (x < 30) begin
        seq.push_back(8'($urandom_range(0, 254)));
      end else if (x < 65) begin
        seq.push_back(B_IAC);
        case ($urandom_range(0, 3))
          0:       seq.push_back(B_DO);
          1:       seq.push_back(B_DONT);
          2:       seq.push_back(B_WILL);
          default: seq.push_back(B_WONT);
        endcase
        case ($urandom_range(0, 5))
          0:       seq.push_back(OPT_ECHO);
          1:       seq.push_back(OPT_SGA);
          2:       seq.push_back(OPT_TTYPE);
          default: seq.push_back(8'($urandom_range(0, 255)));
        endcase
      end else if (x < 78) begin
        seq.push_back(B_IAC);
        seq.push_back(B_SB);
        case ($urandom_range(0, 9))
          0:       opt = B_SE;
          1:       opt = 8'($urandom_range(0, 255));
          default: opt = OPT_TTYPE;
        endcase
        seq.push_back(opt);
        if (opt != B_SE) begin
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0)
              x = B_IAC;
            else
              do x = 8'($urandom_range(0, 255)); while (x == B_SE);
            seq.push_back(x);
          end
          seq.push_back(B_SE);
        end
      end else if (x < 88) begin
        // arbitrary command byte; may land on SB and open a subnegotiation
        seq.push_back(B_IAC);
        seq.push_back(8'($urandom_range(0, 255)));
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end

      foreach (seq[k]) begin
        send_rx(seq[k]);
        if (rx_phase != PH_SUB)
          fed++;
        negotiate(seq[k]);
        foreach (just_due[j]) due_bytes.push_back(just_due[j]);
      end
    end

    // Drain: stop offering, wait for every owed byte, then a short settle.
    idle_on = 1'b0;
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (due_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/tor_pkg.sv
hdl/tor_if.sv
hdl/tor_classifier.sv
hdl/tor_queue.sv
hdl/tor_emitter.sv
hdl/telnet_option_responder.sv
tb/testbench.sv
